### hw/rtl/bfz_pkg.sv
// Package for the 3x3 zero-padded box filter: shared widths, register codes,
// per-item control struct and the divide-by-nine reciprocal.
// No dependencies.
package bfz_pkg;

    localparam int PIXEL_BITS       = 16;
    localparam int MEAN_BITS        = 20;
    localparam int CFG_BITS         = 13;
    localparam int CFG_IDX_BITS     = 1;
    localparam int ROW_BITS         = 12;   // output row counter
    localparam int IN_ROW_BITS      = 13;   // input row runs up to height + 1
    localparam int SUM_BITS         = 20;   // nine 16-bit samples
    localparam int HEIGHT_MAX       = 4096;
    localparam int SIZE_MIN         = 3;
    localparam int FRAME_SIZE_RESET = 2160;

    // floor(sum * 16 / 9) == (sum * ceil(2^28 / 9)) >> 24, exact for sum < 2^23
    localparam int                    RECIP_BITS  = 25;
    localparam int                    RECIP_SHIFT = 24;
    localparam logic [RECIP_BITS-1:0] RECIP_9     = 25'd29826162;

    typedef logic [PIXEL_BITS-1:0] pixel_t;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_reg_t;

    // Per-transaction control, produced by the scan counters at accept time.
    typedef struct packed {
        logic emit;       // this transaction produces a result
        logic col_zero;   // input column is 0: right neighbor column is masked from the sum
        logic left_skip;  // output column 0: left neighbor outside the frame
        logic top_skip;   // output row 0: upper neighbor row outside the frame
        logic bot_skip;   // last output row: lower neighbor row outside the frame
        logic last;       // final output pixel of the frame
    } item_ctl_t;

endpackage

### hw/rtl/bfz_scan_ctrl.sv
// Scan position counters and frame size registers of the box filter.
// Depends on bfz_pkg.
module bfz_scan_ctrl
    import bfz_pkg::*;
#(
    parameter int  MAX_WIDTH = 4096,
    localparam int COL_BITS  = $clog2(MAX_WIDTH)
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]     cfg_data,
    input  logic                    advance,
    output logic [COL_BITS-1:0]     col,
    output item_ctl_t               ctl
);

    localparam int CNT_BITS  = $clog2(MAX_WIDTH + 1);
    localparam int WCMP_BITS = (CNT_BITS > CFG_BITS) ? CNT_BITS : CFG_BITS;
    localparam int RST_WIDTH = (FRAME_SIZE_RESET > MAX_WIDTH) ? MAX_WIDTH : FRAME_SIZE_RESET;
    localparam logic [WCMP_BITS-1:0] W_LIMIT = WCMP_BITS'(MAX_WIDTH);
    localparam logic [WCMP_BITS-1:0] W_MIN   = WCMP_BITS'(SIZE_MIN);

    logic [COL_BITS-1:0]    width_m1_reg;
    logic [CFG_BITS-1:0]    height_reg;
    logic [COL_BITS-1:0]    in_col_reg, in_col_next;
    logic [IN_ROW_BITS-1:0] in_row_reg, in_row_next;
    logic [COL_BITS-1:0]    out_col_reg, out_col_next;
    logic [ROW_BITS-1:0]    out_row_reg, out_row_next;

    logic [WCMP_BITS-1:0]   w_req, w_dec;
    logic [COL_BITS-1:0]    w_eff_m1;
    logic [CFG_BITS-1:0]    h_eff;
    logic [ROW_BITS-1:0]    height_m1;
    logic                   restart;

    // register clamping
    always_comb begin
        w_req = WCMP_BITS'(cfg_data);
        w_dec = w_req - WCMP_BITS'(1);
        if (w_req < W_MIN) begin
            w_eff_m1 = COL_BITS'(SIZE_MIN - 1);
        end else if (w_req > W_LIMIT) begin
            w_eff_m1 = COL_BITS'(MAX_WIDTH - 1);
        end else begin
            w_eff_m1 = w_dec[COL_BITS-1:0];
        end
        if (cfg_data < CFG_BITS'(SIZE_MIN)) begin
            h_eff = CFG_BITS'(SIZE_MIN);
        end else if (cfg_data > CFG_BITS'(HEIGHT_MAX)) begin
            h_eff = CFG_BITS'(HEIGHT_MAX);
        end else begin
            h_eff = cfg_data;
        end
    end

    assign height_m1 = ROW_BITS'(height_reg - CFG_BITS'(1));

    always_comb begin
        ctl.emit      = (in_row_reg >= IN_ROW_BITS'(2)) ||
                        ((in_row_reg == IN_ROW_BITS'(1)) && (in_col_reg != '0));
        ctl.col_zero  = (in_col_reg == '0);
        ctl.left_skip = (out_col_reg == '0);
        ctl.top_skip  = (out_row_reg == '0);
        ctl.bot_skip  = (out_row_reg == height_m1);
        ctl.last      = ctl.emit && ctl.bot_skip && (out_col_reg == width_m1_reg);

        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (ctl.emit) begin
            if (out_col_reg == width_m1_reg) begin
                out_col_next = '0;
                out_row_next = out_row_reg + ROW_BITS'(1);
            end else begin
                out_col_next = out_col_reg + COL_BITS'(1);
            end
        end

        if (in_col_reg == width_m1_reg) begin
            in_col_next = '0;
            in_row_next = in_row_reg + IN_ROW_BITS'(1);
        end else begin
            in_col_next = in_col_reg + COL_BITS'(1);
            in_row_next = in_row_reg;
        end

        restart = ctl.last || (in_row_next > (IN_ROW_BITS'(height_reg) + IN_ROW_BITS'(1)));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_m1_reg <= COL_BITS'(RST_WIDTH - 1);
            height_reg   <= CFG_BITS'(FRAME_SIZE_RESET);
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                REG_FRAME_WIDTH: begin
                    width_m1_reg <= w_eff_m1;
                end
                REG_FRAME_HEIGHT: begin
                    height_reg <= h_eff;
                end
                default: begin
                end
            endcase
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end else if (advance) begin
            if (restart) begin
                in_col_reg  <= '0;
                in_row_reg  <= '0;
                out_col_reg <= '0;
                out_row_reg <= '0;
            end else begin
                in_col_reg  <= in_col_next;
                in_row_reg  <= in_row_next;
                out_col_reg <= out_col_next;
                out_row_reg <= out_row_next;
            end
        end
    end

    assign col = in_col_reg;

endmodule

### hw/rtl/bfz_line_buffer.sv
// Two line stores of the box filter, one row each, with registered reads.
// Depends on bfz_pkg.
module bfz_line_buffer
    import bfz_pkg::*;
#(
    parameter int  DEPTH     = 4096,
    localparam int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                 aclk,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  pixel_t               wr_sample,
    output pixel_t               rd_upper,
    output pixel_t               rd_middle
);

    pixel_t upper_mem  [DEPTH];
    pixel_t middle_mem [DEPTH];
    pixel_t rd_upper_reg;
    pixel_t rd_middle_reg;

    // middle row ages into the upper row at the same address
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_upper_reg  <= upper_mem[rd_addr];
            rd_middle_reg <= middle_mem[rd_addr];
        end
        if (wr_en) begin
            upper_mem[wr_addr]  <= rd_middle_reg;
            middle_mem[wr_addr] <= wr_sample;
        end
    end

    assign rd_upper  = rd_upper_reg;
    assign rd_middle = rd_middle_reg;

endmodule

### hw/rtl/bfz_window_sum.sv
// 3x3 window taps and the masked neighborhood sum of the box filter.
// Depends on bfz_pkg.
module bfz_window_sum
    import bfz_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                shift_en,
    input  item_ctl_t           ctl,
    input  pixel_t              col_upper,
    input  pixel_t              col_middle,
    input  pixel_t              col_lower,
    output logic [SUM_BITS-1:0] sum
);

    // left and center columns; the right column is the incoming one
    pixel_t left_reg   [3];
    pixel_t center_reg [3];
    pixel_t right_col  [3];

    logic   left_en, right_en;
    logic   row_en [3];
    logic [SUM_BITS-1:0] acc;

    assign right_col[0] = col_upper;
    assign right_col[1] = col_middle;
    assign right_col[2] = col_lower;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < 3; r++) begin
                left_reg[r]   <= '0;
                center_reg[r] <= '0;
            end
        end else if (shift_en) begin
            for (int r = 0; r < 3; r++) begin
                left_reg[r]   <= center_reg[r];
                center_reg[r] <= right_col[r];
            end
        end
    end

    // at input column 0 the center is the row's last pixel: no right neighbor
    assign left_en  = !ctl.left_skip;
    assign right_en = !ctl.col_zero;
    assign row_en[0] = !ctl.top_skip;
    assign row_en[1] = 1'b1;
    assign row_en[2] = !ctl.bot_skip;

    always_comb begin
        acc = '0;
        for (int r = 0; r < 3; r++) begin
            if (row_en[r]) begin
                acc = acc + SUM_BITS'(center_reg[r])
                          + (left_en  ? SUM_BITS'(left_reg[r])  : SUM_BITS'(0))
                          + (right_en ? SUM_BITS'(right_col[r]) : SUM_BITS'(0));
            end
        end
    end

    assign sum = acc;

endmodule

### hw/rtl/box_filter_3x3_zero_pad.sv
// Top level of the 3x3 zero-padded box mean filter: handshakes, pipeline
// registers and the divide-by-nine output stage.
// Depends on bfz_pkg, bfz_scan_ctrl, bfz_line_buffer, bfz_window_sum.
//
//  port group   dir  handshake          payload
//  s_*          in   s_valid/s_ready    s_pixel_value[15:0], s_flush
//  m_*          out  m_valid/m_ready    m_mean_value[19:0], m_frame_last
//  cfg_*        in   cfg_wr_en          cfg_index (0 width, 1 height), cfg_data[12:0]
//
//  One transaction per cycle sustained while m_ready is high. A result
//  passes line store read, window sum and reciprocal multiply, each stage
//  holding its own valid bit, so a stalled m_ready only backs up as far
//  as needed. Transactions that produce no result (first row and a pixel)
//  drop out after the window stage. Reset clears control and taps; line
//  stores keep whatever they hold and are only read where the frame edge
//  masks them. A config write restarts the frame at row 0, column 0.
module box_filter_3x3_zero_pad
    import bfz_pkg::*;
#(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    // configuration
    input  logic                    cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]     cfg_data,
    // pixel input
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [PIXEL_BITS-1:0]   s_pixel_value,
    input  logic                    s_flush,
    // mean output
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [MEAN_BITS-1:0]    m_mean_value,
    output logic                    m_frame_last
);

    localparam int COL_BITS  = $clog2(MAX_WIDTH);
    localparam int PROD_BITS = SUM_BITS + RECIP_BITS;

    // handshake chain
    logic                accept;
    logic                out_free, s2_free, s1_free;
    logic                s1_go, s2_go;

    // scan control
    logic [COL_BITS-1:0] acc_col;
    item_ctl_t           acc_ctl;

    // stage 1: line store read in flight
    logic                s1_valid_reg;
    item_ctl_t           s1_ctl_reg;
    pixel_t              s1_sample_reg;
    logic [COL_BITS-1:0] s1_col_reg;
    pixel_t              rd_upper, rd_middle;

    // stage 2: neighborhood sum
    logic                s2_valid_reg;
    logic [SUM_BITS-1:0] s2_sum_reg;
    logic                s2_last_reg;
    logic [SUM_BITS-1:0] win_sum;
    logic [PROD_BITS-1:0] s2_product;

    // output register
    logic                m_valid_reg;
    logic [MEAN_BITS-1:0] m_mean_reg;
    logic                m_last_reg;

    assign out_free = !m_valid_reg || m_ready;
    assign s2_go    = s2_valid_reg && out_free;
    assign s2_free  = !s2_valid_reg || out_free;
    assign s1_go    = s1_valid_reg && s2_free;
    assign s1_free  = !s1_valid_reg || s2_free;
    assign s_ready  = s1_free;
    assign accept   = s_valid && s1_free;

    bfz_scan_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_scan_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .advance   (accept),
        .col       (acc_col),
        .ctl       (acc_ctl)
    );

    // read at accept, write back when the transaction leaves stage 1
    bfz_line_buffer #(
        .DEPTH (MAX_WIDTH)
    ) u_line_buffer (
        .aclk      (aclk),
        .rd_en     (accept),
        .rd_addr   (acc_col),
        .wr_en     (s1_go),
        .wr_addr   (s1_col_reg),
        .wr_sample (s1_sample_reg),
        .rd_upper  (rd_upper),
        .rd_middle (rd_middle)
    );

    bfz_window_sum u_window_sum (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .shift_en   (s1_go),
        .ctl        (s1_ctl_reg),
        .col_upper  (rd_upper),
        .col_middle (rd_middle),
        .col_lower  (s1_sample_reg),
        .sum        (win_sum)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_free) begin
            s1_valid_reg <= s_valid;
        end
    end

    // flush transactions enter as zero samples
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_ctl_reg    <= acc_ctl;
            s1_sample_reg <= s_flush ? '0 : s_pixel_value;
            s1_col_reg    <= acc_col;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s2_free) begin
            s2_valid_reg <= s1_go && s1_ctl_reg.emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_go) begin
            s2_sum_reg  <= win_sum;
            s2_last_reg <= s1_ctl_reg.last;
        end
    end

    // sum * 16 / 9 by reciprocal multiply
    assign s2_product = s2_sum_reg * RECIP_9;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_go) begin
            m_mean_reg <= s2_product[RECIP_SHIFT +: MEAN_BITS];
            m_last_reg <= s2_last_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_mean_value = m_mean_reg;
    assign m_frame_last = m_last_reg;

    // write-back and new read never collide on one line store address, except
    // right after the frame's last pixel, where the stale read feeds only
    // rows outside the new frame
    a_no_rw_collision: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_go && accept && !s1_ctl_reg.last) |-> (s1_col_reg != acc_col))
        else $error("line store read and write hit the same column");

    // after the frame's final result the scan restarts at row 0, column 0
    a_frame_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && acc_ctl.last) |=> (!acc_ctl.emit && acc_ctl.col_zero))
        else $error("scan did not restart after the last pixel");

    // an input at column 0 centers on the row's last pixel, never on column 0
    a_col_zero_center: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && s1_ctl_reg.emit && s1_ctl_reg.col_zero) |-> !s1_ctl_reg.left_skip)
        else $error("column 0 input centered on the first output column");

endmodule
